FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character table of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 24;
   localparam int CAP_WIDTH           = 24;
   localparam int OUT_COUNT_WIDTH     = 24;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_DONE_OK  = 2'd1;
   localparam logic [1:0] KIND_DONE_ERR = 2'd2;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] PLUS_VALUE  = 6'd62;
   localparam logic [5:0] SLASH_VALUE = 6'd63;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_data_type;

   typedef struct packed {
      logic [1:0]                 record_kind;
      logic [7:0]                 data_byte;
      logic [OUT_COUNT_WIDTH-1:0] byte_count;
      logic                       last_of_run;
   } rsp_data_type;

   // One queued job: the bytes of a finished group and/or a completion record.
   typedef struct packed {
      logic [1:0]                 byte_num;
      logic [23:0]                bytes;
      logic [OUT_COUNT_WIDTH-1:0] base_count;
      logic                       has_done;
      logic                       done_err;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      logic [7:0] t;
      s.valid = 1'b1;
      s.value = 6'd0;
      t       = 8'd0;
      case (ch) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
            t = ch - CHAR_UPPER_A;
            s.value = t[5:0];
         end
         [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
            t = ch - CHAR_LOWER_A + LOWER_BASE;
            s.value = t[5:0];
         end
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: begin
            t = ch - CHAR_DIGIT_0 + DIGIT_BASE;
            s.value = t[5:0];
         end
         CHAR_PLUS:  s.value = PLUS_VALUE;
         CHAR_SLASH: s.value = SLASH_VALUE;
         default:    s.valid = 1'b0;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, checks the grammar, gathers groups and the byte count,
// and pushes one job per item that causes results.
// ----------------------------------------------------------------------------
module b64d_front #(
   parameter int COUNT_WIDTH = b64d_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [b64d_pkg::CAP_WIDTH-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  b64d_pkg::req_data_type           req_data,
   input  logic                             queue_full,
   output logic                             push,
   output b64d_pkg::job_type                push_job
);
   import b64d_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH + 1 > CAP_WIDTH) ? COUNT_WIDTH + 1 : CAP_WIDTH;

   logic [CAP_WIDTH-1:0]   capacity_ff;
   logic [1:0]             position_ff, position_in;
   logic [23:0]            acc_ff, acc_in;
   logic [1:0]             pad_ff, pad_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   error_ff, error_in;

   sextet_type           sx;
   logic                 accept;
   logic                 err;
   logic                 emit;
   logic [1:0]           pad_n;
   logic [23:0]          acc_n;
   logic [1:0]           nbytes;
   logic [COUNT_WIDTH:0] after;
   logic                 over;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sx     = sextet_of(req_data.text_char);
      err    = 1'b0;
      emit   = 1'b0;
      pad_n  = pad_ff;
      acc_n  = acc_ff;
      nbytes = 2'd0;
      after  = '0;
      over   = 1'b0;

      position_in = position_ff;
      acc_in      = acc_ff;
      pad_in      = pad_ff;
      count_in    = count_ff;
      error_in    = error_ff;

      if (req_data.text_char == CHAR_PAD) begin
         if (position_ff < 2'd2) begin
            err = 1'b1;
         end else begin
            pad_n = pad_ff + 2'd1;
            acc_n = {acc_ff[17:0], 6'd0};
         end
      end else begin
         if (pad_ff != 2'd0 || !sx.valid) begin
            err = 1'b1;
         end else begin
            acc_n = {acc_ff[17:0], sx.value};
         end
      end

      nbytes = 2'd3 - pad_n;
      after  = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(nbytes);
      // The top bit of the widened sum means the counter itself would wrap.
      over   = (CMP_WIDTH'(after) > CMP_WIDTH'(capacity_ff)) || after[COUNT_WIDTH];

      if (!err) begin
         if (position_ff == 2'd3) begin
            if (pad_n != 2'd0 && !req_data.end_of_text) begin
               err = 1'b1;
            end else if (over) begin
               err = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end else if (req_data.end_of_text) begin
            err = 1'b1;
         end
      end
      if (error_ff) begin
         err  = 1'b0;
         emit = 1'b0;
      end

      if (accept) begin
         if (req_data.end_of_text) begin
            position_in = 2'd0;
            acc_in      = 24'd0;
            pad_in      = 2'd0;
            count_in    = '0;
            error_in    = 1'b0;
         end else if (!error_ff) begin
            if (err) begin
               error_in = 1'b1;
            end else if (emit) begin
               position_in = 2'd0;
               acc_in      = 24'd0;
               pad_in      = 2'd0;
               count_in    = after[COUNT_WIDTH-1:0];
            end else begin
               position_in = position_ff + 2'd1;
               acc_in      = acc_n;
               pad_in      = pad_n;
            end
         end
      end

      push                = accept && (emit || req_data.end_of_text);
      push_job.byte_num   = emit ? nbytes : 2'd0;
      push_job.bytes      = acc_n;
      push_job.base_count = OUT_COUNT_WIDTH'({{(OUT_COUNT_WIDTH){1'b0}}, count_ff});
      push_job.has_done   = req_data.end_of_text;
      push_job.done_err   = error_ff || err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         position_ff <= 2'd0;
         acc_ff      <= 24'd0;
         pad_ff      <= 2'd0;
         count_ff    <= '0;
         error_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         position_ff <= position_in;
         acc_ff      <= acc_in;
         pad_ff      <= pad_in;
         count_ff    <= count_in;
         error_ff    <= error_in;
      end
   end

endmodule

FILE: rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64d_pkg::job_type head_job
);
   import b64d_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   job_type              store_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full       = (fill_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = store_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands each job into byte and completion records, one per cycle while the
// output is not held back by rsp_ready, into a registered output.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  b64d_pkg::job_type       head_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output b64d_pkg::rsp_data_type  rsp_data
);
   import b64d_pkg::*;

   logic         work_valid_ff, work_valid_in;
   job_type      job_ff, job_in;
   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic         advance;
   logic         last_rec;
   logic [2:0]   total;
   logic         is_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      total    = {1'b0, job_ff.byte_num} + {2'b00, job_ff.has_done};
      last_rec = ({1'b0, idx_ff} + 3'd1) == total;
      is_byte  = idx_ff < job_ff.byte_num;
      advance  = work_valid_ff && (!rsp_valid_ff || rsp_ready);
      pop      = head_valid && (!work_valid_ff || (advance && last_rec));

      work_valid_in = work_valid_ff;
      job_in        = job_ff;
      idx_in        = idx_ff;
      if (pop) begin
         work_valid_in = 1'b1;
         job_in        = head_job;
         idx_in        = 2'd0;
      end else if (advance) begin
         if (last_rec) begin
            work_valid_in = 1'b0;
         end
         idx_in = idx_ff + 2'd1;
      end

      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in.last_of_run = last_rec;
         if (is_byte) begin
            rsp_data_in.record_kind = KIND_BYTE;
            case (idx_ff)
               2'd0:    rsp_data_in.data_byte = job_ff.bytes[23:16];
               2'd1:    rsp_data_in.data_byte = job_ff.bytes[15:8];
               default: rsp_data_in.data_byte = job_ff.bytes[7:0];
            endcase
            rsp_data_in.byte_count = job_ff.base_count
                                   + OUT_COUNT_WIDTH'(idx_ff) + OUT_COUNT_WIDTH'(1);
         end else begin
            rsp_data_in.record_kind = job_ff.done_err ? KIND_DONE_ERR : KIND_DONE_OK;
            rsp_data_in.data_byte   = 8'd0;
            rsp_data_in.byte_count  = job_ff.base_count
                                    + OUT_COUNT_WIDTH'(job_ff.byte_num);
         end
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/base64_stream_decoder_unit.sv
// The first result of an item passes through the queue, the back's job register and
// its output register. One character is accepted per cycle while the queue has room;
// results leave at one per cycle while rsp_ready is high, so an item with n results
// holds the back until all n have left. The rate is set by the single output register
// of the back, fed by the 4-entry queue. Reset (synchronous, active high) clears the
// group state, count, error, capacity and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Padded base64 decoder: a front checks and groups characters, a back emits
// decoded bytes and completion records.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit #(
   parameter int COUNT_WIDTH = b64d_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [b64d_pkg::CAP_WIDTH-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  b64d_pkg::req_data_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output b64d_pkg::rsp_data_type         rsp_data
);
   import b64d_pkg::*;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   b64d_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives base64 texts one character per item into the stream decoder, with
// random gaps on both channels. It predicts every byte and completion record
// from its own copy of the decoder state, and compares each record in order.
// ----------------------------------------------------------------------------

typedef logic [7:0] char_queue_type[$];

class decode_predictor;

   localparam logic [24:0] COUNT_MAX = 25'h0FFFFFF;

   logic [23:0] capacity;
   logic [1:0]  group_pos;
   logic [23:0] sextets;
   logic [1:0]  pads;
   logic [24:0] emitted;
   bit          error_seen;

   b64d_pkg::rsp_data_type pending_records[$];

   int mismatches;
   int bytes_checked;
   int clean_done;
   int error_done;

   function new();
      capacity      = '0;
      mismatches    = 0;
      bytes_checked = 0;
      clean_done    = 0;
      error_done    = 0;
      clear_text();
   endfunction

   function void clear_text();
      group_pos  = '0;
      sextets    = '0;
      pads       = '0;
      emitted    = '0;
      error_seen = 0;
   endfunction

   function void set_capacity(logic [23:0] value);
      capacity = value;
   endfunction

   // Bit 6 flags a base64 digit, bits 5:0 hold its value.
   function logic [6:0] digit_value(logic [7:0] ch);
      logic [7:0] v;
      v = 8'd0;
      if (ch >= b64d_pkg::CHAR_UPPER_A && ch <= b64d_pkg::CHAR_UPPER_Z)
         v = ch - b64d_pkg::CHAR_UPPER_A;
      else if (ch >= b64d_pkg::CHAR_LOWER_A && ch <= b64d_pkg::CHAR_LOWER_Z)
         v = ch - b64d_pkg::CHAR_LOWER_A + 8'd26;
      else if (ch >= b64d_pkg::CHAR_DIGIT_0 && ch <= b64d_pkg::CHAR_DIGIT_9)
         v = ch - b64d_pkg::CHAR_DIGIT_0 + 8'd52;
      else if (ch == b64d_pkg::CHAR_PLUS)
         v = 8'd62;
      else if (ch == b64d_pkg::CHAR_SLASH)
         v = 8'd63;
      else
         return 7'd0;
      return {1'b1, v[5:0]};
   endfunction

   // Returns 1 when the item does something, 0 when it is ignored after an error.
   function bit note_char(b64d_pkg::req_data_type item);
      b64d_pkg::rsp_data_type recs[4];
      logic [7:0]  ch;
      logic [6:0]  dv;
      logic [24:0] after;
      logic [23:0] shifted;
      bit          eot;
      bit          bad;
      bit          active;
      int          nbytes;
      int          n;
      ch     = item.text_char;
      eot    = item.end_of_text;
      active = !error_seen || eot;
      n      = 0;
      if (!error_seen) begin
         bad = 0;
         if (ch == b64d_pkg::CHAR_PAD) begin
            if (group_pos < 2) begin
               bad = 1;
            end else begin
               pads    = pads + 2'd1;
               sextets = {sextets[17:0], 6'd0};
            end
         end else begin
            dv = digit_value(ch);
            if (pads != 0 || !dv[6])
               bad = 1;
            else
               sextets = {sextets[17:0], dv[5:0]};
         end
         if (!bad) begin
            if (group_pos == 2'd3) begin
               if (pads != 0 && !eot) begin
                  bad = 1;
               end else begin
                  nbytes = 3 - int'(pads);
                  after  = emitted + 25'(nbytes);
                  if (after > {1'b0, capacity} || after > COUNT_MAX) begin
                     bad = 1;
                  end else begin
                     for (int i = 0; i < nbytes; i++) begin
                        shifted = sextets >> (16 - 8 * i);
                        emitted = emitted + 25'd1;
                        recs[n].record_kind = b64d_pkg::KIND_BYTE;
                        recs[n].data_byte   = shifted[7:0];
                        recs[n].byte_count  = emitted[23:0];
                        recs[n].last_of_run = 1'b0;
                        n++;
                     end
                     group_pos = '0;
                     sextets   = '0;
                     pads      = '0;
                  end
               end
            end else if (eot) begin
               bad = 1;
            end else begin
               group_pos = group_pos + 2'd1;
            end
         end
         if (bad)
            error_seen = 1;
      end
      if (eot) begin
         recs[n].record_kind = error_seen ? b64d_pkg::KIND_DONE_ERR : b64d_pkg::KIND_DONE_OK;
         recs[n].data_byte   = 8'd0;
         recs[n].byte_count  = emitted[23:0];
         recs[n].last_of_run = 1'b0;
         n++;
         clear_text();
      end
      if (n > 0)
         recs[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++)
         pending_records.push_back(recs[i]);
      return active;
   endfunction

   task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   task check_record(b64d_pkg::rsp_data_type got);
      b64d_pkg::rsp_data_type want;
      if (pending_records.size() == 0) begin
         report($sformatf("unexpected record kind %0d byte %02h count %0d last %0d",
                          got.record_kind, got.data_byte, got.byte_count, got.last_of_run));
         return;
      end
      want = pending_records.pop_front();
      if (got.record_kind !== want.record_kind)
         report($sformatf("record_kind %0d, expected %0d", got.record_kind,
                          want.record_kind));
      if (got.data_byte !== want.data_byte)
         report($sformatf("data_byte %02h, expected %02h", got.data_byte, want.data_byte));
      if (got.byte_count !== want.byte_count)
         report($sformatf("byte_count %0d, expected %0d", got.byte_count, want.byte_count));
      if (got.last_of_run !== want.last_of_run)
         report($sformatf("last_of_run %0d, expected %0d", got.last_of_run,
                          want.last_of_run));
      if (want.record_kind == b64d_pkg::KIND_BYTE)
         bytes_checked++;
      else if (want.record_kind == b64d_pkg::KIND_DONE_OK)
         clean_done++;
      else
         error_done++;
   endtask

endclass

module testbench;

   import b64d_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 190;
   localparam int PHASE_ITEMS    = 40;
   localparam int SETTLE_CYCLES  = 12;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         csr_write_enable = 1'b0;
   logic [23:0]  csr_write_data   = '0;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   req_data_type req_data         = '0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b0;
   rsp_data_type rsp_data;

   decode_predictor predictor = new();

   bit calm = 0;
   int active_items = 0;
   int texts_sent = 0;
   int settings_used = 0;

   base64_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   always #5 clock = ~clock;

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] digit_char(int v);
      if (v < 26)
         return CHAR_UPPER_A + 8'(v);
      else if (v < 52)
         return CHAR_LOWER_A + 8'(v - 26);
      else if (v < 62)
         return CHAR_DIGIT_0 + 8'(v - 52);
      else if (v == 62)
         return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic char_queue_type chars_of(string s);
      char_queue_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   // Appends groups of random digits; the last group carries the given padding.
   function automatic void add_groups(ref char_queue_type q, input int groups,
                                      input int pad_chars);
      for (int g = 0; g < groups; g++)
         for (int k = 0; k < 4; k++)
            if (g == groups - 1 && k >= 4 - pad_chars)
               q.push_back(CHAR_PAD);
            else
               q.push_back(digit_char($urandom_range(0, 63)));
   endfunction

   task automatic send_char(logic [7:0] ch, logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{text_char: ch, end_of_text: eot};
      do
         @(posedge clock);
      while (!req_ready);
      if (predictor.note_char('{text_char: ch, end_of_text: eot}))
         active_items++;
   endtask

   task automatic send_text(char_queue_type text);
      for (int i = 0; i < text.size(); i++)
         send_char(text[i], i == text.size() - 1);
      texts_sent++;
   endtask

   // The block is idle once every record is in and the last ignored items
   // have had time to drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (predictor.pending_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [23:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      predictor.set_capacity(value);
      settings_used++;
   endtask

   task automatic random_text();
      char_queue_type text;
      int r;
      int p;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         add_groups(text, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8)
                                                       : $urandom_range(1, 4),
                    $urandom_range(0, 2));
      end else if (r < 80) begin
         add_groups(text, $urandom_range(1, 3), $urandom_range(0, 2));
         p = $urandom_range(0, text.size() - 1);
         case ($urandom_range(0, 3))
            0: text[p] = CHAR_PAD;
            1: text[p] = 8'($urandom_range(0, 255));
            2: void'(text.pop_back());
            default: text.push_back(digit_char($urandom_range(0, 63)));
         endcase
      end else if (r < 90) begin
         // A padded group that is not the last one.
         add_groups(text, 1, $urandom_range(1, 2));
         add_groups(text, $urandom_range(1, 2), 0);
      end else begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end
      send_text(text);
   endtask

   // Receiver: checks each accepted record and stalls at random.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready)
               predictor.check_record(rsp_data);
            if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall_left = pick_gap();
            end
         end
      end
   end

   // Ends the run when neither channel moves an item for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TIMEOUT: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int phase;
      logic [23:0] cap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With room for five bytes the second group of the
      // first text overflows after three bytes have gone out.
      write_capacity(24'd5);
      send_text(chars_of("AZaz09+/"));
      send_text(chars_of("QQ=="));
      send_text(chars_of("A="));
      send_text(chars_of("AB=C"));
      send_text(chars_of("QQ==A"));
      send_text('{8'hFF});
      send_text(chars_of("AB"));

      phase = 0;
      active_items = 0;
      while (active_items < RANDOM_ITEMS) begin
         case (phase % 6)
            0: cap = 24'hFFFFFF;
            1: cap = 24'd0;
            2: cap = 24'($urandom_range(1, 9));
            3: cap = 24'($urandom);
            4: cap = 24'($urandom_range(10, 30));
            default: cap = 24'hFFFFFF;
         endcase
         write_capacity(cap);
         calm = (phase % 6 == 2);
         while (active_items < (phase + 1) * PHASE_ITEMS && active_items < RANDOM_ITEMS)
            random_text();
         calm = 0;
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d texts (%0d random items acted on) under %0d capacity settings.",
               texts_sent, active_items, settings_used);
      $display("Checked %0d bytes, %0d clean and %0d failed completions.",
               predictor.bytes_checked, predictor.clean_done, predictor.error_done);
      if (predictor.mismatches == 0 && predictor.pending_records.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
